### sv/swx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swx_pkg
// Shared codes, constants and the event record for the swatch stream parser.
// ----------------------------------------------------------------------------
package swx_pkg;

	localparam logic [2:0] EV_GBEGIN   = 3'd0;
	localparam logic [2:0] EV_CBEGIN   = 3'd1;
	localparam logic [2:0] EV_UNIT     = 3'd2;
	localparam logic [2:0] EV_CHAN     = 3'd3;
	localparam logic [2:0] EV_BADMODEL = 3'd4;
	localparam logic [2:0] EV_GEND     = 3'd5;

	localparam logic [15:0] CLS_COLOUR = 16'h0001;
	localparam logic [15:0] CLS_GBEGIN = 16'hC001;
	localparam logic [15:0] CLS_GEND   = 16'hC002;

	localparam logic [31:0] MODEL_CMYK = 32'h434D594B;
	localparam logic [31:0] MODEL_RGB  = 32'h52474220;
	localparam logic [31:0] MODEL_LAB  = 32'h4C414220;
	localparam logic [31:0] MODEL_GRAY = 32'h47726179;

	localparam logic [1:0] MC_CMYK = 2'd0;
	localparam logic [1:0] MC_RGB  = 2'd1;
	localparam logic [1:0] MC_LAB  = 2'd2;
	localparam logic [1:0] MC_GRAY = 2'd3;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [2:0]  event_res;
		logic [31:0] payload;
		logic [1:0]  channel_number;
		logic [1:0]  colour_model;
		logic        final_channel;
		logic        final_name_unit;
	} event_t;

	// Index of the last channel for each colour model.
	function automatic logic [1:0] last_channel(input logic [1:0] model);
		case (model)
			MC_CMYK: last_channel = 2'd3;
			MC_RGB:  last_channel = 2'd2;
			MC_LAB:  last_channel = 2'd2;
			default: last_channel = 2'd0;
		endcase
	endfunction

endpackage

### sv/swatch_exchange_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swatch_exchange_stream_parser
// Streaming parser for swatch-exchange files, one byte per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one file byte per item, with new_file
// set on the first byte of a file to restart at the 12-byte header.
// Output channel (out_valid/out_ready): one event per item: group or colour
// begin with the name length, UTF-16 name units, channel words (float bits,
// big-endian), unknown model words and group ends.
// Throughput: one byte per cycle while the queue is not full. Each byte
// is taken by the front state machine; events pass through a 4-entry queue.
// Path: an event is written into the queue when the byte that completes it is
// accepted, then loaded into the output register that drives out_valid.
// Reset: arst_n clears the parser to the header phase and empties the queue
// and output register.
// Receiver stall: the output register holds its event, the queue fills and
// in_ready drops once four events are waiting.
// ----------------------------------------------------------------------------
module swatch_exchange_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        new_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [31:0] payload,
	output logic [1:0]  channel_number,
	output logic [1:0]  colour_model,
	output logic        final_channel,
	output logic        final_name_unit
);
	import swx_pkg::*;

	logic   push, pop, q_full, q_empty;
	event_t push_ev, q_head, out_ev;

	swx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.new_file  (new_file),
		.q_full    (q_full),
		.push      (push),
		.push_ev   (push_ev)
	);

	swx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (q_head)
	);

	swx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_ev    (out_ev)
	);

	assign event_res       = out_ev.event_res;
	assign payload         = out_ev.payload;
	assign channel_number  = out_ev.channel_number;
	assign colour_model    = out_ev.colour_model;
	assign final_channel   = out_ev.final_channel;
	assign final_name_unit = out_ev.final_name_unit;

endmodule

### sv/swx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swx_front
// Byte front end: assembles big-endian words, tracks the block structure and
// pushes one event record into the queue when a field that yields an event completes.
// ----------------------------------------------------------------------------
module swx_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            new_file,
	input  logic            q_full,
	output logic            push,
	output swx_pkg::event_t push_ev
);
	import swx_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER, PH_CLASS, PH_SIZE, PH_NAMELEN, PH_NAME, PH_MODEL, PH_CHAN, PH_TYPE
	} phase_t;

	phase_t      phase_q, ph_cur, phase_n;
	logic [3:0]  byte_index_q, bi_n, needed;
	logic [31:0] word_q, word_n;
	logic        colour_q, colour_n;
	logic [15:0] units_q, units_n, units_dec;
	logic [1:0]  model_q, model_n;
	logic [1:0]  chan_q, chan_n;
	logic        accept, done, emit;
	logic [15:0] lo;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;

	always_comb begin
		ph_cur    = new_file ? PH_HEADER : phase_q;
		word_n    = new_file ? {24'd0, data_byte} : {word_q[23:0], data_byte};
		bi_n      = new_file ? 4'd1 : byte_index_q + 4'd1;
		case (ph_cur)
			PH_HEADER: needed = 4'd12;
			PH_SIZE, PH_MODEL, PH_CHAN: needed = 4'd4;
			default: needed = 4'd2;
		endcase
		done      = bi_n >= needed;
		lo        = word_n[15:0];
		units_dec = units_q - 16'd1;
		phase_n   = ph_cur;
		colour_n  = colour_q;
		units_n   = units_q;
		model_n   = model_q;
		chan_n    = chan_q;
		emit      = 1'b0;
		push_ev   = '0;
		if (done) begin
			case (ph_cur)
				PH_HEADER: phase_n = PH_CLASS;
				PH_CLASS: begin
					if (lo == CLS_COLOUR || lo == CLS_GBEGIN) begin
						colour_n = (lo == CLS_COLOUR);
						phase_n  = PH_SIZE;
					end else if (lo == CLS_GEND) begin
						emit              = 1'b1;
						push_ev.event_res = EV_GEND;
					end
				end
				PH_SIZE: phase_n = PH_NAMELEN;
				PH_NAMELEN: begin
					emit              = 1'b1;
					push_ev.event_res = colour_q ? EV_CBEGIN : EV_GBEGIN;
					push_ev.payload   = {16'd0, lo};
					units_n           = lo;
					if (lo == 16'd0)
						phase_n = colour_q ? PH_MODEL : PH_CLASS;
					else
						phase_n = PH_NAME;
				end
				PH_NAME: begin
					emit                    = 1'b1;
					units_n                 = units_dec;
					push_ev.event_res       = EV_UNIT;
					push_ev.payload         = {16'd0, lo};
					push_ev.final_name_unit = (units_dec == 16'd0);
					if (units_dec == 16'd0)
						phase_n = colour_q ? PH_MODEL : PH_CLASS;
				end
				PH_MODEL: begin
					chan_n  = 2'd0;
					phase_n = PH_CHAN;
					if (word_n == MODEL_CMYK)
						model_n = MC_CMYK;
					else if (word_n == MODEL_RGB)
						model_n = MC_RGB;
					else if (word_n == MODEL_LAB)
						model_n = MC_LAB;
					else if (word_n == MODEL_GRAY)
						model_n = MC_GRAY;
					else begin
						emit              = 1'b1;
						push_ev.event_res = EV_BADMODEL;
						push_ev.payload   = word_n;
						phase_n           = PH_TYPE;
					end
				end
				PH_CHAN: begin
					emit                   = 1'b1;
					push_ev.event_res      = EV_CHAN;
					push_ev.payload        = word_n;
					push_ev.channel_number = chan_q;
					push_ev.colour_model   = model_q;
					push_ev.final_channel  = (chan_q == last_channel(model_q));
					if (chan_q == last_channel(model_q)) begin
						chan_n  = 2'd0;
						phase_n = PH_TYPE;
					end else begin
						chan_n = chan_q + 2'd1;
					end
				end
				default: phase_n = PH_CLASS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			byte_index_q <= 4'd0;
			word_q       <= 32'd0;
			colour_q     <= 1'b0;
			units_q      <= 16'd0;
			model_q      <= 2'd0;
			chan_q       <= 2'd0;
		end else if (accept) begin
			phase_q      <= phase_n;
			byte_index_q <= done ? 4'd0 : bi_n;
			word_q       <= done ? 32'd0 : word_n;
			colour_q     <= colour_n;
			units_q      <= units_n;
			model_q      <= model_n;
			chan_q       <= chan_n;
		end
	end

endmodule

### sv/swx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swx_queue
// Short event queue between the byte front end and the output stage.
// ----------------------------------------------------------------------------
module swx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  swx_pkg::event_t push_ev,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output swx_pkg::event_t head
);
	import swx_pkg::*;

	event_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     count_q;

	assign full  = (count_q == QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule

### sv/swx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swx_back
// Output stage: takes event records from the queue and holds each one on the
// result channel until the receiver takes it.
// ----------------------------------------------------------------------------
module swx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  swx_pkg::event_t q_head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output swx_pkg::event_t out_ev
);
	import swx_pkg::*;

	logic   valid_q;
	event_t ev_q;

	assign pop       = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_ev    = ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the next item; payload needs no reset.
	always_ff @(posedge clk) begin
		if (pop)
			ev_q <= q_head;
	end

endmodule

### sv/swx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swx_checker
// Port-level checks on the swatch stream parser result channel.
// ----------------------------------------------------------------------------
module swx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_res,
	input logic [31:0] payload,
	input logic [1:0]  channel_number,
	input logic [1:0]  colour_model,
	input logic        final_channel,
	input logic        final_name_unit
);
	import swx_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(payload))
		else $error("result item changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= EV_GEND)
		else $error("undefined event code");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_CHAN && colour_model == MC_GRAY |->
			final_channel && channel_number == 2'd0)
		else $error("gray colour must have a single channel");

	a_nochan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_CHAN |->
			channel_number == 2'd0 && colour_model == 2'd0 && !final_channel)
		else $error("channel fields set on a non-channel event");

	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_UNIT |-> !final_name_unit &&
			(event_res != EV_GEND || payload == 32'd0))
		else $error("name flag or group end payload wrong");

endmodule

bind swatch_exchange_stream_parser swx_checker u_swx_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.event_res       (event_res),
	.payload         (payload),
	.channel_number  (channel_number),
	.colour_model    (colour_model),
	.final_channel   (final_channel),
	.final_name_unit (final_name_unit)
);
